// ===== rtl/blpg_pkg.sv =====
package blpg_pkg;

   localparam int COORD_BITS    = 12;
   localparam int DIM_BITS      = 12;
   localparam int ADDR_BITS     = 22;
   localparam int COLOR_BITS    = 32;
   localparam int DEC_BITS      = COORD_BITS + 3;
   localparam int CSR_IDX_BITS  = 2;
   localparam int MAX_DIM_DEF   = 2048;

   localparam logic [DIM_BITS-1:0] WIDTH_RESET  = DIM_BITS'(640);
   localparam logic [DIM_BITS-1:0] HEIGHT_RESET = DIM_BITS'(480);

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [COORD_BITS:0]   delta_type;
   typedef logic signed [DEC_BITS-1:0]   decision_type;
   typedef logic [DIM_BITS-1:0]          dim_type;
   typedef logic [ADDR_BITS-1:0]         addr_type;
   typedef logic [COLOR_BITS-1:0]        color_type;

   typedef enum logic [0:0] {
      OP_LOAD = 1'b0,
      OP_TICK = 1'b1
   } op_type;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_SCREEN_WIDTH  = 2'd0,
      CSR_SCREEN_HEIGHT = 2'd1
   } csr_index_type;

   typedef struct packed {
      logic         active;
      logic         steep;
      coord_type    major_pos;
      coord_type    major_end;
      coord_type    minor_pos;
      logic         minor_neg;
      decision_type decision;
      decision_type step_move;
      decision_type step_keep;
      color_type    color;
   } line_state_type;

   typedef struct packed {
      logic      busy_pixel;
      logic      write_valid;
      coord_type pixel_x;
      coord_type pixel_y;
      addr_type  pixel_address;
      color_type pixel_color;
      logic      last_pixel;
   } pixel_result_type;

endpackage

// ===== rtl/blpg_req_if.sv =====
interface blpg_req_if;
   import blpg_pkg::*;

   logic      valid;
   logic      ready;
   op_type    op;
   coord_type start_x;
   coord_type start_y;
   coord_type end_x;
   coord_type end_y;
   color_type line_color;

   modport source (output valid, op, start_x, start_y, end_x, end_y, line_color,
                   input ready);
   modport sink (input valid, op, start_x, start_y, end_x, end_y, line_color,
                 output ready);
endinterface

// ===== rtl/blpg_rsp_if.sv =====
interface blpg_rsp_if;
   import blpg_pkg::*;

   logic      valid;
   logic      ready;
   logic      busy_pixel;
   logic      write_valid;
   coord_type pixel_x;
   coord_type pixel_y;
   addr_type  pixel_address;
   color_type pixel_color;
   logic      last_pixel;

   modport source (output valid, busy_pixel, write_valid, pixel_x, pixel_y,
                   pixel_address, pixel_color, last_pixel,
                   input ready);
   modport sink (input valid, busy_pixel, write_valid, pixel_x, pixel_y,
                 pixel_address, pixel_color, last_pixel,
                 output ready);
endinterface

// ===== rtl/blpg_csr_if.sv =====
interface blpg_csr_if;
   import blpg_pkg::*;

   logic          valid;
   logic          ready;
   csr_index_type index;
   dim_type       data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/bresenham_line_pixel_generator_core.sv =====
// Bresenham line engine that turns line requests into frame-buffer writes.
// The req channel takes two kinds of request: a load (two endpoints and a
// color), which starts a new line, drops any unfinished one and yields no
// response, and a tick, which yields exactly one response holding the next
// pixel of the line, or an all-zero response when no line is active.
// The csr channel sets the screen width (index 0) and height (index 1);
// values above MAX_DIM saturate, other indexes are ignored. It is always
// ready and must only be written while the engine is quiet.
// Latency: a tick's response is valid in the cycle after the request is
// taken. Throughput: one request per cycle while the response register
// can take it; the pixel select, clip compare and the 12x12 address
// multiply sit between the line state register and the response register.
// The response register decouples the two sides: a new request is taken
// whenever that register is empty or being drained in the same cycle, so a
// stalled receiver holds the engine only while the register is full.
// Synchronous reset clears the active line and the pending response and
// restores the screen size to 640 by 480.
module bresenham_line_pixel_generator_core #(
   parameter int MAX_DIM = blpg_pkg::MAX_DIM_DEF
) (
   input logic        clock,
   input logic        reset,
   blpg_req_if.sink   req_bus,
   blpg_rsp_if.source rsp_bus,
   blpg_csr_if.sink   csr_bus
);
   import blpg_pkg::*;

   localparam int SAT_BITS = 17;

   line_state_type   state_ff, state_in;
   line_state_type   init_state, step_state;
   pixel_result_type pix_result;
   pixel_result_type result_ff, result_in;
   logic             rsp_valid_ff, rsp_valid_in;
   dim_type          width_ff, width_in;
   dim_type          height_ff, height_in;
   dim_type          csr_sat;
   logic             req_accept, is_tick;

   blpg_setup u_setup (
      .start_x    (req_bus.start_x),
      .start_y    (req_bus.start_y),
      .end_x      (req_bus.end_x),
      .end_y      (req_bus.end_y),
      .line_color (req_bus.line_color),
      .init_state (init_state)
   );

   blpg_pixel u_pixel (
      .cur_state     (state_ff),
      .screen_width  (width_ff),
      .frame_height  (height_ff),
      .result        (pix_result),
      .next_state    (step_state)
   );

   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign csr_bus.ready = 1'b1;
   assign req_accept    = req_bus.valid && req_bus.ready;
   assign is_tick       = req_bus.op == OP_TICK;

   always_comb begin
      csr_sat = (SAT_BITS'(csr_bus.data) > SAT_BITS'(MAX_DIM))
                ? DIM_BITS'(MAX_DIM) : csr_bus.data;
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_bus.valid) begin
         case (csr_bus.index)
            CSR_SCREEN_WIDTH:  width_in  = csr_sat;
            CSR_SCREEN_HEIGHT: height_in = csr_sat;
            default: ;
         endcase
      end

      state_in = state_ff;
      if (req_accept) begin
         state_in = is_tick ? step_state : init_state;
      end

      rsp_valid_in = (req_accept && is_tick) || (rsp_valid_ff && !rsp_bus.ready);
      result_in    = (req_accept && is_tick) ? pix_result : result_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         width_ff     <= WIDTH_RESET;
         height_ff    <= HEIGHT_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
      end
   end

   always_ff @(posedge clock) begin
      result_ff <= result_in;
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.busy_pixel    = result_ff.busy_pixel;
   assign rsp_bus.write_valid   = result_ff.write_valid;
   assign rsp_bus.pixel_x       = result_ff.pixel_x;
   assign rsp_bus.pixel_y       = result_ff.pixel_y;
   assign rsp_bus.pixel_address = result_ff.pixel_address;
   assign rsp_bus.pixel_color   = result_ff.pixel_color;
   assign rsp_bus.last_pixel    = result_ff.last_pixel;

`ifndef SYNTHESIS
   // A load never creates a response of its own.
   assert property (@(posedge clock) disable iff (reset)
      (req_accept && !is_tick && (!rsp_valid_ff || rsp_bus.ready)) |=> !rsp_valid_ff)
      else $error("load request produced a response");

   // Emitting the last pixel ends the line.
   assert property (@(posedge clock) disable iff (reset)
      (req_accept && is_tick && state_ff.active
       && state_ff.major_pos == state_ff.major_end) |=> !state_ff.active)
      else $error("line still active after its last pixel");

   // A pixel write is only issued for a pixel of an active line.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && result_ff.write_valid) |-> result_ff.busy_pixel)
      else $error("frame-buffer write without a line pixel");

   // Screen size registers stay within the saturation limit.
   assert property (@(posedge clock) disable iff (reset)
      (SAT_BITS'(width_ff) <= SAT_BITS'(MAX_DIM))
      && (SAT_BITS'(height_ff) <= SAT_BITS'(MAX_DIM)))
      else $error("screen size register above limit");
`endif

endmodule

// ===== rtl/blpg_setup.sv =====
module blpg_setup (
   input  blpg_pkg::coord_type      start_x,
   input  blpg_pkg::coord_type      start_y,
   input  blpg_pkg::coord_type      end_x,
   input  blpg_pkg::coord_type      end_y,
   input  blpg_pkg::color_type      line_color,
   output blpg_pkg::line_state_type init_state
);
   import blpg_pkg::*;

   delta_type    dx, dy, adx, ady;
   delta_type    dmaj, dmin, admin;
   coord_type    amaj, amin, bmaj, bmin;
   logic         steep;
   decision_type twice_min;

   always_comb begin
      dx    = delta_type'(end_x) - delta_type'(start_x);
      dy    = delta_type'(end_y) - delta_type'(start_y);
      adx   = dx[COORD_BITS] ? -dx : dx;
      ady   = dy[COORD_BITS] ? -dy : dy;
      steep = ady > adx;

      // The major axis always counts upward from the endpoint with the lower major coordinate.
      if (steep) begin
         if (end_y > start_y) begin
            amaj = start_y; amin = start_x; bmaj = end_y; bmin = end_x;
         end else begin
            amaj = end_y; amin = end_x; bmaj = start_y; bmin = start_x;
         end
      end else begin
         if (end_x > start_x) begin
            amaj = start_x; amin = start_y; bmaj = end_x; bmin = end_y;
         end else begin
            amaj = end_x; amin = end_y; bmaj = start_x; bmin = start_y;
         end
      end

      dmaj      = delta_type'(bmaj) - delta_type'(amaj);
      dmin      = delta_type'(bmin) - delta_type'(amin);
      admin     = dmin[COORD_BITS] ? -dmin : dmin;
      twice_min = decision_type'({admin, 1'b0});

      init_state.active    = 1'b1;
      init_state.steep     = steep;
      init_state.major_pos = amaj;
      init_state.major_end = bmaj;
      init_state.minor_pos = amin;
      init_state.minor_neg = dmin[COORD_BITS];
      init_state.decision  = twice_min - decision_type'(dmaj);
      init_state.step_move = twice_min - decision_type'({dmaj, 1'b0});
      init_state.step_keep = twice_min;
      init_state.color     = line_color;
   end

endmodule

// ===== rtl/blpg_pixel.sv =====
module blpg_pixel (
   input  blpg_pkg::line_state_type   cur_state,
   input  blpg_pkg::dim_type          screen_width,
   input  blpg_pkg::dim_type          frame_height,
   output blpg_pkg::pixel_result_type result,
   output blpg_pkg::line_state_type   next_state
);
   import blpg_pkg::*;

   localparam int PROD_BITS = 2 * DIM_BITS;

   coord_type                px, py;
   logic                     on_screen, last;
   dim_type                  row;
   logic [PROD_BITS-1:0]     prod, addr_full;

   always_comb begin
      px   = cur_state.steep ? cur_state.minor_pos : cur_state.major_pos;
      py   = cur_state.steep ? cur_state.major_pos : cur_state.minor_pos;
      last = cur_state.major_pos == cur_state.major_end;

      on_screen = !px[COORD_BITS-1]
                  && (delta_type'(px) < delta_type'({1'b0, screen_width}))
                  && !py[COORD_BITS-1]
                  && (delta_type'(py) < delta_type'({1'b0, frame_height}));

      // The frame buffer stores rows top first, so y is flipped.
      row       = frame_height - DIM_BITS'(1) - DIM_BITS'(unsigned'(py));
      prod      = PROD_BITS'(row) * PROD_BITS'(screen_width);
      addr_full = prod + PROD_BITS'(unsigned'(px));

      if (cur_state.active) begin
         result.busy_pixel    = 1'b1;
         result.write_valid   = on_screen;
         result.pixel_x       = px;
         result.pixel_y       = py;
         result.pixel_address = on_screen ? ADDR_BITS'(addr_full) : '0;
         result.pixel_color   = cur_state.color;
         result.last_pixel    = last;
      end else begin
         result = '0;
      end

      next_state = cur_state;
      if (cur_state.active) begin
         if (last) begin
            next_state.active = 1'b0;
         end else begin
            next_state.major_pos = cur_state.major_pos + coord_type'(1);
            if (cur_state.decision > decision_type'(0)) begin
               next_state.minor_pos = cur_state.minor_neg
                                      ? cur_state.minor_pos - coord_type'(1)
                                      : cur_state.minor_pos + coord_type'(1);
               next_state.decision  = cur_state.decision + cur_state.step_move;
            end else begin
               next_state.decision  = cur_state.decision + cur_state.step_keep;
            end
         end
      end
   end

endmodule
